// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Clock and reset are taken from the
// enclosing module, which names them clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define LPBD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lpbd assertion failed");

// Same-cycle implication.
`define LPBD_ASSERT_IMPL(label, ante, cons) `LPBD_ASSERT(label, (ante) |-> (cons))

`endif

// ===== rtl/lpbd_pkg.sv =====
package lpbd_pkg;

  // fixed field widths
  localparam int WordW  = 32;
  localparam int AvailW = $clog2(WordW + 1);
  localparam int SkipW  = 5;
  localparam int ByteW  = 8;
  localparam int ValidW = 4;
  localparam int IndexW = 32;

  // depth of the word queue between front and back
  localparam int QDepth = 2;

  localparam logic [SkipW-1:0] SkipReset = 5'd8;

  // head of the word queue as seen by the parser
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
  } word_q_t;

  // one result item
  typedef struct packed {
    logic [ByteW-1:0]  frame_byte;
    logic [ValidW-1:0] valid_bits;
    logic              frame_last;
    logic [IndexW-1:0] frame_index;
  } result_t;

endpackage

// ===== rtl/lpbd_word_fifo.sv =====
`include "assert_macros.svh"

module lpbd_word_fifo import lpbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WordW-1:0] word_i,
  output word_q_t          head_o,
  input  logic             pop_i
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  logic [WordW-1:0] mem_q [QDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push;

  assign in_ready_o = (cnt_q != CntW'(QDepth));
  assign push       = in_valid_i && in_ready_o;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.word  = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= word_i;
    end
  end

  `LPBD_ASSERT(a_cnt_bound, cnt_q <= CntW'(QDepth))
  `LPBD_ASSERT_IMPL(a_pop_nonempty, pop_i, cnt_q != '0)

endmodule

// ===== rtl/lpbd_bit_parser.sv =====
`include "assert_macros.svh"

module lpbd_bit_parser import lpbd_pkg::*; #(
  parameter int LengthBits = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SkipW-1:0] skip_i,
  input  word_q_t          head_i,
  output logic             pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o
);

  localparam int LenCntW = $clog2(LengthBits + 1);
  localparam int CntW    = (LenCntW > SkipW) ? LenCntW : SkipW;
  localparam int ShW     = LengthBits + WordW;

  // parse phases
  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]            phase_q, phase_d;
  logic [CntW-1:0]       pos_q, pos_d;
  logic [LengthBits-1:0] carry_q, carry_d;
  logic [LengthBits-1:0] rem_q, rem_d;
  logic [IndexW-1:0]     cnt_q, cnt_d;
  logic [WordW-1:0]      word_q, word_d;
  logic [AvailW-1:0]     avail_q, avail_d;
  logic                  out_valid_q, out_valid_d;
  result_t               out_q, out_d;

  logic [AvailW-1:0]     need, take, avail_new, bleft;
  logic [CntW-1:0]       pos_new;
  logic [ShW-1:0]        sh;
  logic [LengthBits-1:0] len_new, rem_new;
  logic [ByteW-1:0]      byte_new;
  logic [ValidW-1:0]     pad;
  logic                  skip_done, emit, step_en, out_free, load;
  result_t               res_d;

  // one piece per cycle unless stalled: bits to field end or word end
  always_comb begin
    skip_done = (pos_q >= CntW'(skip_i));
    bleft     = AvailW'(ByteW) - AvailW'(pos_q);
    unique case (phase_q)
      PH_SKIP: need = skip_done ? '0 : AvailW'(CntW'(skip_i) - pos_q);
      PH_DATA: need = (rem_q < LengthBits'(bleft)) ? AvailW'(rem_q) : bleft;
      default: need = AvailW'(LengthBits) - AvailW'(pos_q);
    endcase
    take      = (need < avail_q) ? need : avail_q;
    sh        = {carry_q, word_q} << take;
    len_new   = sh[ShW-1 -: LengthBits];
    byte_new  = len_new[ByteW-1:0];
    pos_new   = pos_q + CntW'(take);
    rem_new   = rem_q - LengthBits'(take);
    avail_new = avail_q - take;
    pad       = ValidW'(ByteW) - ValidW'(pos_new);

    // result of this piece, if it closes a byte or an empty frame
    res_d.frame_index = cnt_q;
    unique case (phase_q)
      PH_SKIP: begin
        emit             = 1'b0;
        res_d.frame_byte = '0;
        res_d.valid_bits = '0;
        res_d.frame_last = 1'b0;
      end
      PH_DATA: begin
        emit             = (pos_new == CntW'(ByteW)) || (rem_new == '0);
        res_d.frame_byte = ByteW'(byte_new << pad);
        res_d.valid_bits = ValidW'(pos_new);
        res_d.frame_last = (rem_new == '0);
      end
      default: begin
        emit             = (pos_new == CntW'(LengthBits)) && (len_new == '0);
        res_d.frame_byte = '0;
        res_d.valid_bits = '0;
        res_d.frame_last = 1'b1;
      end
    endcase
  end

  assign out_free = !out_valid_q || res_ready_i;
  assign step_en  = (avail_q != '0) && (!emit || out_free);
  assign load     = head_i.valid && ((avail_q == '0) || (step_en && (avail_new == '0)));
  assign pop_o    = load;

  // parse state update
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    carry_d     = carry_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    avail_d     = avail_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (step_en) begin
      word_d  = sh[WordW-1:0];
      avail_d = avail_new;
      unique case (phase_q)
        PH_SKIP: begin
          if (skip_done) begin
            phase_d = PH_LEN;
            pos_d   = '0;
            carry_d = '0;
          end else begin
            pos_d = pos_new;
          end
        end
        PH_DATA: begin
          carry_d = LengthBits'(byte_new);
          pos_d   = pos_new;
          rem_d   = rem_new;
          if (emit) begin
            carry_d = '0;
            pos_d   = '0;
            if (rem_new == '0) begin
              cnt_d   = cnt_q + IndexW'(1);
              phase_d = PH_LEN;
            end
          end
        end
        default: begin
          phase_d = PH_LEN;
          carry_d = len_new;
          pos_d   = pos_new;
          if (pos_new == CntW'(LengthBits)) begin
            rem_d   = len_new;
            carry_d = '0;
            pos_d   = '0;
            if (len_new != '0) begin
              phase_d = PH_DATA;
            end else begin
              cnt_d = cnt_q + IndexW'(1);
            end
          end
        end
      endcase
    end

    if (load) begin
      word_d  = head_i.word;
      avail_d = AvailW'(WordW);
    end

    // output register
    if (step_en && emit) begin
      out_valid_d = 1'b1;
      out_d       = res_d;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP;
      pos_q       <= '0;
      carry_q     <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      avail_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      carry_q     <= carry_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      avail_q     <= avail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    out_q  <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  `LPBD_ASSERT(a_avail_bound, avail_q <= AvailW'(WordW))
  `LPBD_ASSERT_IMPL(a_data_rem, phase_q == PH_DATA, rem_q != '0)
  `LPBD_ASSERT(a_frame_count, (step_en && emit && res_d.frame_last) |=> (cnt_q == $past(cnt_q) + IndexW'(1)))

endmodule

// ===== rtl/length_prefixed_bit_frame_deframer_top.sv =====
// Length-prefixed bit frame deframer. Takes 32-bit stream words on the input
// channel, reads their bits MSB first, drops lead_skip_bits bits at stream
// start, then repeatedly reads a LengthBits-wide frame length and hands out
// the frame's payload as bytes, one item per byte, the last byte marked and a
// short final byte left-aligned; an empty frame yields one item with
// valid_bits 0. Words enter a two-entry queue, so the input can take up to
// two words while the parser or the output side stalls. The parser works one
// field piece per cycle while it holds a word and its output register can
// take an item (a piece is a run of bits up to the end of the current skip,
// length or byte field, or up to the end of the word). The output register
// issues at most one item per cycle. lead_skip_bits resets to 8 and is only
// read during the lead skip; write it while idle.
module length_prefixed_bit_frame_deframer_top import lpbd_pkg::*; #(
  parameter int LengthBits = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SkipW-1:0]  lead_skip_bits_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [WordW-1:0]  stream_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ByteW-1:0]  frame_byte_o,
  output logic [ValidW-1:0] valid_bits_o,
  output logic              frame_last_o,
  output logic [IndexW-1:0] frame_index_o
);

  logic [SkipW-1:0] skip_q;
  word_q_t          head;
  logic             pop;
  result_t          res;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= SkipReset;
    end else if (cfg_valid_i) begin
      skip_q <= lead_skip_bits_i;
    end
  end

  // front: word queue
  lpbd_word_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .word_i     (stream_word_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // back: bit parser with output register
  lpbd_bit_parser #(
    .LengthBits (LengthBits)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .skip_i      (skip_q),
    .head_i      (head),
    .pop_o       (pop),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign frame_byte_o  = res.frame_byte;
  assign valid_bits_o  = res.valid_bits;
  assign frame_last_o  = res.frame_last;
  assign frame_index_o = res.frame_index;

endmodule

// ===== sim/length_prefixed_bit_frame_deframer_top_test.sv =====
`timescale 1ns / 1ps

module length_prefixed_bit_frame_deframer_top_test import lpbd_pkg::*; ;

  localparam int LenW         = 20;
  localparam int WordsPerPass = 60;
  localparam int SettleCycles = 16;
  localparam int CycleLimit   = 200000;

  // parser phases, as the deframer walks the bit stream
  typedef enum logic [1:0] {
    PH_SKIP    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // one directed row: the word, and up to two results typed in by hand
  // (n_fixed of zero: the results come from the predictor)
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [1:0]       n_fixed;
    result_t          fix0;
    result_t          fix1;
  } dir_row_t;

  localparam result_t NoRes = '0;

  // lead skip is 0 for this stretch, so the first bit is a length bit
  localparam dir_row_t DirRows [12] = '{
    // empty frame, then 12 length bits gathered
    {32'h0000_0000, 2'd1, {8'h00, 4'd0, 1'b1, 32'd0}, NoRes},
    // two more empty frames
    {32'h0000_0000, 2'd2, {8'h00, 4'd0, 1'b1, 32'd1}, {8'h00, 4'd0, 1'b1, 32'd2}},
    // length 8, one full byte
    {32'h0008_FF00, 2'd1, {8'hFF, 4'd8, 1'b1, 32'd3}, NoRes},
    // length 1, single set bit left-aligned
    {32'h0018_0000, 2'd1, {8'h80, 4'd1, 1'b1, 32'd4}, NoRes},
    // length 1 with a clear bit, then a 40-bit frame starts
    {32'h8000_A3FF, 2'd2, {8'h00, 4'd1, 1'b1, 32'd5}, {8'hFF, 4'd8, 1'b0, 32'd6}},
    {32'hFFFF_FFF0, 2'd0, NoRes, NoRes},
    // 64-bit frame
    {32'h0010_3FFF, 2'd1, {8'hFF, 4'd8, 1'b0, 32'd7}, NoRes},
    {32'hFFFF_FFFF, 2'd0, NoRes, NoRes},
    {32'h0000_0000, 2'd0, NoRes, NoRes},
    // 3-bit frame, then a 16-bit frame starts
    {32'h0E80_0086, 2'd1, {8'hA0, 4'd3, 1'b1, 32'd8}, NoRes},
    {32'hAAA8_0000, 2'd0, NoRes, NoRes},
    {32'h0000_0000, 2'd2, {8'h00, 4'd0, 1'b1, 32'd10}, {8'h00, 4'd0, 1'b1, 32'd11}}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [SkipW-1:0]  lead_skip_bits_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [WordW-1:0]  stream_word_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ByteW-1:0]  frame_byte_o;
  logic [ValidW-1:0] valid_bits_o;
  logic              frame_last_o;
  logic [IndexW-1:0] frame_index_o;

  // predictor state
  logic [SkipW-1:0]  skip_cfg;
  logic [5:0]        p_pos;
  logic [LenW-1:0]   p_carry;
  phase_e            p_phase;
  logic [LenW-1:0]   p_left;
  logic [IndexW-1:0] p_frame;

  result_t           due_bytes [$];
  bit                plan_bits [$];
  int                mismatch_count = 0;
  int                cycle_count    = 0;
  bit                no_idle        = 1'b0;

  length_prefixed_bit_frame_deframer_top #(
    .LengthBits(LenW)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .lead_skip_bits_i (lead_skip_bits_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .stream_word_i    (stream_word_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_o     (frame_byte_o),
    .valid_bits_o     (valid_bits_o),
    .frame_last_o     (frame_last_o),
    .frame_index_o    (frame_index_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // one line per mismatch, and a count
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // walk one word through the parser, MSB first; keep=0 only moves state
  task automatic deframe_word(input logic [WordW-1:0] w, input bit keep);
    result_t r;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (p_phase == PH_SKIP && p_pos < skip_cfg) begin
        p_pos++;
      end else begin
        if (p_phase == PH_SKIP) begin
          p_phase = PH_LENGTH;
          p_pos   = '0;
          p_carry = '0;
        end
        if (p_phase == PH_PAYLOAD) begin
          p_carry = {p_carry[LenW-2:0], w[i]} & LenW'('hFF);
          p_pos++;
          p_left--;
          if (p_pos >= 8 || p_left == '0) begin
            r.frame_byte  = p_carry[7:0] << (8 - p_pos);
            r.valid_bits  = p_pos[ValidW-1:0];
            r.frame_last  = (p_left == '0);
            r.frame_index = p_frame;
            if (keep) due_bytes.push_back(r);
            p_carry = '0;
            p_pos   = '0;
            if (r.frame_last) begin
              p_frame++;
              p_phase = PH_LENGTH;
            end
          end
        end else begin
          // length field; the spare phase code behaves the same way
          p_phase = PH_LENGTH;
          p_carry = {p_carry[LenW-2:0], w[i]};
          p_pos++;
          if (p_pos >= LenW) begin
            p_left  = p_carry;
            p_carry = '0;
            p_pos   = '0;
            if (p_left == '0) begin
              r = {8'h00, 4'd0, 1'b1, p_frame};
              if (keep) due_bytes.push_back(r);
              p_frame++;
            end else begin
              p_phase = PH_PAYLOAD;
            end
          end
        end
      end
    end
  endtask

  // append one frame to the planned bit stream: length field, then payload
  task automatic add_frame(input int len_w);
    int unsigned     pick;
    int unsigned     fill;
    logic [LenW-1:0] flen;
    pick = $urandom_range(0, 99);
    if (pick < 10)      flen = '0;
    else if (pick < 70) flen = LenW'($urandom_range(1, 40));
    else if (pick < 95) flen = LenW'($urandom_range(41, 200));
    else                flen = LenW'($urandom_range(201, 600));
    if (len_w < LenW) flen = flen & LenW'((32'd1 << len_w) - 32'd1);
    for (int k = len_w - 1; k >= 0; k--) plan_bits.push_back(flen[k]);
    fill = $urandom_range(0, 9);
    for (int k = 0; k < flen; k++) begin
      if (fill == 0)      plan_bits.push_back(1'b1);
      else if (fill == 1) plan_bits.push_back(1'b0);
      else                plan_bits.push_back(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic next_stream_word(output logic [WordW-1:0] w);
    while (plan_bits.size() < WordW) add_frame(LenW);
    for (int k = WordW - 1; k >= 0; k--) w[k] = plan_bits.pop_front();
  endtask

  // offer one word from a falling edge, return at the falling edge after it
  // is taken; fixed results replace the predicted ones for that word
  task automatic push_word(input logic [WordW-1:0] w, input logic [1:0] n_fixed,
                           input result_t fix0, input result_t fix1);
    while (!no_idle && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    deframe_word(w, n_fixed == 2'd0);
    if (n_fixed >= 2'd1) due_bytes.push_back(fix0);
    if (n_fixed == 2'd2) due_bytes.push_back(fix1);
    @(negedge clk_i);
  endtask

  task automatic write_lead_skip(input logic [SkipW-1:0] v);
    cfg_valid_i      <= 1'b1;
    lead_skip_bits_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    skip_cfg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // all results in, then let a word that ends mid-field finish
  task automatic wait_idle();
    while (due_bytes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // result side: ready dropped at random except in the quiet pass
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= no_idle || ($urandom_range(0, 99) >= 7);
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_bytes.size() == 0) begin
        note_mismatch("unexpected item, frame_byte", 32'(frame_byte_o), '0);
      end else begin
        want = due_bytes.pop_front();
        if (frame_byte_o !== want.frame_byte)
          note_mismatch("frame_byte", 32'(frame_byte_o), 32'(want.frame_byte));
        if (valid_bits_o !== want.valid_bits)
          note_mismatch("valid_bits", 32'(valid_bits_o), 32'(want.valid_bits));
        if (frame_last_o !== want.frame_last)
          note_mismatch("frame_last", 32'(frame_last_o), 32'(want.frame_last));
        if (frame_index_o !== want.frame_index)
          note_mismatch("frame_index", frame_index_o, want.frame_index);
      end
    end
  end

  // stimulus
  initial begin
    logic [WordW-1:0] w;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    lead_skip_bits_i = '0;
    in_valid_i       = 1'b0;
    stream_word_i    = '0;
    skip_cfg         = SkipReset;
    p_pos            = '0;
    p_carry          = '0;
    p_phase          = PH_SKIP;
    p_left           = '0;
    p_frame          = '0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows with no lead skip
    write_lead_skip('0);
    for (int n = 0; n < 12; n++)
      push_word(DirRows[n].word, DirRows[n].n_fixed, DirRows[n].fix0, DirRows[n].fix1);
    in_valid_i <= 1'b0;

    // the directed rows leave 11 length bits gathered, all zero
    add_frame(LenW - 11);

    // random passes; the skip is past, so these writes must change nothing
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0:       write_lead_skip(5'd31);
        1:       write_lead_skip(SkipW'($urandom_range(0, 31)));
        2:       write_lead_skip(SkipReset);
        default: write_lead_skip('0);
      endcase
      no_idle = (ph == 2);
      for (int n = 0; n < WordsPerPass; n++) begin
        next_stream_word(w);
        push_word(w, 2'd0, NoRes, NoRes);
      end
      in_valid_i <= 1'b0;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== length_prefixed_bit_frame_deframer_top.f =====
+incdir+rtl
rtl/lpbd_pkg.sv
rtl/lpbd_word_fifo.sv
rtl/lpbd_bit_parser.sv
rtl/length_prefixed_bit_frame_deframer_top.sv
sim/length_prefixed_bit_frame_deframer_top_test.sv
